@@ hw/rtl/dnfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfc_pkg
// Shared types, character codes, parse phases and power-of-ten tables for the
// decimal number field classifier.
// ----------------------------------------------------------------------------
package dnfc_pkg;

    localparam int EXP_MAX         = 999;
    localparam int FRAC_DIGITS_MAX = 32;
    localparam int EXP_W           = $clog2(EXP_MAX + 1);
    localparam int FRAC_W          = $clog2(FRAC_DIGITS_MAX + 1);
    localparam int MANT_W          = 63;
    localparam int DEXP_W          = 12;
    localparam int POW_COUNT       = 19;
    localparam int POW_W           = 60;
    localparam int IDX_W           = $clog2(POW_COUNT);

    localparam logic [MANT_W-1:0] MAG_MAX = '1;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_INT   = 3'd1;
    localparam logic [2:0] PH_FRAC  = 3'd2;
    localparam logic [2:0] PH_EXP   = 3'd3;
    localparam logic [2:0] PH_EXPD  = 3'd4;

    localparam logic [1:0] KIND_STR = 2'd0;
    localparam logic [1:0] KIND_INT = 2'd1;
    localparam logic [1:0] KIND_FLT = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty_req;
    } t_in;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [63:0]       int_value;
        logic [MANT_W-1:0]        mantissa;
        logic                     mant_negative;
        logic signed [DEXP_W-1:0] dec_exponent;
        logic                     overflow;
    } t_out;

    typedef struct packed {
        logic [1:0]               kind;
        logic [MANT_W-1:0]        mant;
        logic                     neg;
        logic signed [DEXP_W-1:0] dexp;
        logic                     ovf;
        logic [EXP_W-1:0]         exp;
    } t_fin;

    function automatic logic [POW_W-1:0] pow10_lut(input logic [IDX_W-1:0] idx);
        logic [POW_W-1:0] v;
        unique case (idx)
            5'd0:    v = 60'd1;
            5'd1:    v = 60'd10;
            5'd2:    v = 60'd100;
            5'd3:    v = 60'd1000;
            5'd4:    v = 60'd10000;
            5'd5:    v = 60'd100000;
            5'd6:    v = 60'd1000000;
            5'd7:    v = 60'd10000000;
            5'd8:    v = 60'd100000000;
            5'd9:    v = 60'd1000000000;
            5'd10:   v = 60'd10000000000;
            5'd11:   v = 60'd100000000000;
            5'd12:   v = 60'd1000000000000;
            5'd13:   v = 60'd10000000000000;
            5'd14:   v = 60'd100000000000000;
            5'd15:   v = 60'd1000000000000000;
            5'd16:   v = 60'd10000000000000000;
            5'd17:   v = 60'd100000000000000000;
            5'd18:   v = 60'd1000000000000000000;
            default: v = '0;
        endcase
        return v;
    endfunction

    // largest mantissa whose product with ten to idx stays in range
    function automatic logic [MANT_W-1:0] mag_limit_lut(input logic [IDX_W-1:0] idx);
        logic [MANT_W-1:0] v;
        unique case (idx)
            5'd0:    v = 63'd9223372036854775807;
            5'd1:    v = 63'd922337203685477580;
            5'd2:    v = 63'd92233720368547758;
            5'd3:    v = 63'd9223372036854775;
            5'd4:    v = 63'd922337203685477;
            5'd5:    v = 63'd92233720368547;
            5'd6:    v = 63'd9223372036854;
            5'd7:    v = 63'd922337203685;
            5'd8:    v = 63'd92233720368;
            5'd9:    v = 63'd9223372036;
            5'd10:   v = 63'd922337203;
            5'd11:   v = 63'd92233720;
            5'd12:   v = 63'd9223372;
            5'd13:   v = 63'd922337;
            5'd14:   v = 63'd92233;
            5'd15:   v = 63'd9223;
            5'd16:   v = 63'd922;
            5'd17:   v = 63'd92;
            5'd18:   v = 63'd9;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/dnfc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfc_parser
// Character recognizer: sign, digits, point, fraction, exponent. Keeps the
// per-field state and registers one finished record at the field's end.
// ----------------------------------------------------------------------------
module dnfc_parser
    import dnfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_in,
    output logic o_stall,
    output logic o_fin_valid,
    output t_fin o_fin,
    input  logic i_fin_ready
);

    logic [2:0]        r_phase, n_phase;
    logic [1:0]        r_kind, n_kind;
    logic              r_neg, n_neg;
    logic [MANT_W-1:0] r_acc, n_acc;
    logic [FRAC_W-1:0] r_fcnt, n_fcnt;
    logic              r_eneg, n_eneg;
    logic [EXP_W-1:0]  r_eacc, n_eacc;
    logic              r_sat, n_sat;
    logic              r_stopped, n_stopped;
    logic              r_s1_valid;
    t_fin              r_s1;

    logic              w_s1_ready;
    logic              w_acc;
    logic              w_emit;
    logic [7:0]        w_c;
    logic [7:0]        w_dsub;
    logic [3:0]        w_d;
    logic              w_dig;
    logic              w_is_e;
    logic [MANT_W+3:0] w_mac;
    logic              w_mac_ovf;
    logic [MANT_W-1:0] w_push;
    logic [EXP_W+3:0]  w_emac;
    logic              w_emac_ovf;
    logic signed [DEXP_W-1:0] w_e12;
    logic signed [DEXP_W-1:0] w_f12;
    t_fin              w_fin;

    assign w_s1_ready = !r_s1_valid || i_fin_ready;
    assign o_stall    = !w_s1_ready;
    assign w_acc      = i_valid && w_s1_ready;
    assign w_emit     = i_in.empty_req || i_in.last;

    assign w_c    = i_in.ch;
    assign w_dsub = w_c - CH_0;
    assign w_d    = w_dsub[3:0];
    assign w_dig  = (w_c >= CH_0) && (w_c <= CH_9);
    assign w_is_e = (w_c == CH_LO_E) || (w_c == CH_UP_E);

    assign w_mac     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {{MANT_W{1'b0}}, w_d};
    assign w_mac_ovf = w_mac > {4'b0, MAG_MAX};
    assign w_push    = w_mac_ovf ? MAG_MAX : w_mac[MANT_W-1:0];

    assign w_emac     = ({4'b0, r_eacc} << 3) + ({4'b0, r_eacc} << 1) + {{EXP_W{1'b0}}, w_d};
    assign w_emac_ovf = w_emac > (EXP_W + 4)'(EXP_MAX);

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_fcnt    = r_fcnt;
        n_eneg    = r_eneg;
        n_eacc    = r_eacc;
        n_sat     = r_sat;
        n_stopped = r_stopped;
        if (!r_stopped) begin
            unique case (r_phase)
                PH_START: begin
                    priority if (w_c == CH_PLUS) begin
                        n_phase = PH_INT;
                    end else if (w_c == CH_MINUS) begin
                        n_phase = PH_INT;
                        n_neg   = 1'b1;
                    end else if (w_dig) begin
                        n_phase = PH_INT;
                        n_acc   = {{(MANT_W-4){1'b0}}, w_d};
                    end else if (w_c == CH_POINT) begin
                        n_phase = PH_FRAC;
                        n_kind  = KIND_FLT;
                    end else begin
                        n_kind    = KIND_STR;
                        n_stopped = 1'b1;
                    end
                end
                PH_INT: begin
                    priority if (w_dig) begin
                        n_acc = w_push;
                        if (w_mac_ovf) begin
                            n_sat = 1'b1;
                        end
                    end else if (w_c == CH_POINT) begin
                        n_phase = PH_FRAC;
                        n_kind  = KIND_FLT;
                    end else if (w_is_e) begin
                        n_phase = PH_EXP;
                    end else begin
                        n_kind    = KIND_STR;
                        n_stopped = 1'b1;
                    end
                end
                PH_FRAC: begin
                    priority if (w_dig) begin
                        if (r_fcnt >= FRAC_W'(FRAC_DIGITS_MAX)) begin
                            n_sat = 1'b1;
                        end else begin
                            n_acc  = w_push;
                            n_fcnt = r_fcnt + 1'b1;
                            if (w_mac_ovf) begin
                                n_sat = 1'b1;
                            end
                        end
                    end else if (w_is_e) begin
                        n_phase = PH_EXP;
                    end else begin
                        n_kind    = KIND_STR;
                        n_stopped = 1'b1;
                    end
                end
                PH_EXP: begin
                    priority if (w_c == CH_PLUS) begin
                        n_phase = PH_EXPD;
                    end else if (w_c == CH_MINUS) begin
                        n_phase = PH_EXPD;
                        n_eneg  = 1'b1;
                        n_kind  = KIND_FLT;
                    end else if (w_dig) begin
                        n_phase = PH_EXPD;
                        n_eacc  = {{(EXP_W-4){1'b0}}, w_d};
                    end else begin
                        n_kind    = KIND_STR;
                        n_stopped = 1'b1;
                    end
                end
                PH_EXPD: begin
                    if (w_dig) begin
                        n_eacc = w_emac_ovf ? EXP_W'(EXP_MAX) : w_emac[EXP_W-1:0];
                        if (w_emac_ovf) begin
                            n_sat = 1'b1;
                        end
                    end else begin
                        n_kind    = KIND_STR;
                        n_stopped = 1'b1;
                    end
                end
                default: begin
                    n_kind    = KIND_STR;
                    n_stopped = 1'b1;
                end
            endcase
        end
    end

    assign w_e12 = DEXP_W'(n_eacc);
    assign w_f12 = DEXP_W'(n_fcnt);

    always_comb begin
        w_fin.kind = n_kind;
        w_fin.mant = n_acc;
        w_fin.neg  = n_neg;
        w_fin.dexp = (n_eneg ? -w_e12 : w_e12) - w_f12;
        w_fin.ovf  = n_sat;
        w_fin.exp  = n_eacc;
        if (i_in.empty_req || (n_kind == KIND_STR)) begin
            w_fin = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_kind     <= KIND_INT;
            r_neg      <= 1'b0;
            r_acc      <= '0;
            r_fcnt     <= '0;
            r_eneg     <= 1'b0;
            r_eacc     <= '0;
            r_sat      <= 1'b0;
            r_stopped  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                if (w_emit) begin
                    r_phase   <= PH_START;
                    r_kind    <= KIND_INT;
                    r_neg     <= 1'b0;
                    r_acc     <= '0;
                    r_fcnt    <= '0;
                    r_eneg    <= 1'b0;
                    r_eacc    <= '0;
                    r_sat     <= 1'b0;
                    r_stopped <= 1'b0;
                end else begin
                    r_phase   <= n_phase;
                    r_kind    <= n_kind;
                    r_neg     <= n_neg;
                    r_acc     <= n_acc;
                    r_fcnt    <= n_fcnt;
                    r_eneg    <= n_eneg;
                    r_eacc    <= n_eacc;
                    r_sat     <= n_sat;
                    r_stopped <= n_stopped;
                end
            end
            if (w_s1_ready) begin
                r_s1_valid <= w_acc && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1 <= w_fin;
        end
    end

    assign o_fin_valid = r_s1_valid;
    assign o_fin       = r_s1;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_EXPD)
        else $error("parse phase out of range");

    a_stopped_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_kind == KIND_STR))
        else $error("stopped field not classed as string");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FRAC_W'(FRAC_DIGITS_MAX))
        else $error("fraction digit count past limit");

endmodule

@@ hw/rtl/dnfc_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfc_scaler
// Integer value path: range check against a power-of-ten table, split
// partial-product multiply, final sum with sign, and the result register.
// ----------------------------------------------------------------------------
module dnfc_scaler
    import dnfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fin_valid,
    input  t_fin i_fin,
    output logic o_fin_ready,
    input  logic i_stall,
    output logic o_valid,
    output t_out o_out
);

    typedef struct packed {
        t_fin             fin;
        logic             int_sat;
        logic [POW_W-1:0] pow;
    } t_s2;

    typedef struct packed {
        t_fin        fin;
        logic        int_sat;
        logic [63:0] pp0;
        logic [62:0] pp1;
        logic [59:0] pp2;
    } t_s3;

    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;
    t_s2  r_s2;
    t_s3  r_s3;
    t_out r_out;

    logic             w_out_ready;
    logic             w_s3_ready;
    logic             w_s2_ready;
    logic             w_small;
    logic [IDX_W-1:0] w_idx;
    t_s2              w_s2;
    t_s3              w_s3;
    logic [31:0]      w_mid;
    logic [63:0]      w_mag;
    t_out             w_out;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_s3_ready  = !r_s3_valid || w_out_ready;
    assign w_s2_ready  = !r_s2_valid || w_s3_ready;
    assign o_fin_ready = w_s2_ready;

    assign w_small = i_fin.exp < EXP_W'(POW_COUNT);
    assign w_idx   = i_fin.exp[IDX_W-1:0];

    always_comb begin
        w_s2.fin     = i_fin;
        w_s2.pow     = pow10_lut(w_idx);
        w_s2.int_sat = (i_fin.kind == KIND_INT) && (i_fin.mant != '0)
                       && (!w_small || (i_fin.mant > mag_limit_lut(w_idx)));
        if (w_s2.int_sat) begin
            w_s2.fin.ovf = 1'b1;
        end
    end

    always_comb begin
        w_s3.fin     = r_s2.fin;
        w_s3.int_sat = r_s2.int_sat;
        w_s3.pp0     = r_s2.fin.mant[31:0] * r_s2.pow[31:0];
        w_s3.pp1     = r_s2.fin.mant[62:32] * r_s2.pow[31:0];
        w_s3.pp2     = r_s2.fin.mant[31:0] * r_s2.pow[59:32];
    end

    // only the low 64 bits matter: an in-range product stays below 2^63
    assign w_mid = r_s3.pp1[31:0] + r_s3.pp2[31:0];

    always_comb begin
        w_mag = r_s3.pp0 + {w_mid, 32'b0};
        if (r_s3.int_sat) begin
            w_mag = {1'b0, MAG_MAX};
        end
        if (r_s3.fin.kind != KIND_INT) begin
            w_mag = '0;
        end
        w_out.kind          = r_s3.fin.kind;
        w_out.int_value     = r_s3.fin.neg ? -w_mag : w_mag;
        w_out.mantissa      = r_s3.fin.mant;
        w_out.mant_negative = r_s3.fin.neg;
        w_out.dec_exponent  = r_s3.fin.dexp;
        w_out.overflow      = r_s3.fin.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s2_ready) begin
                r_s2_valid <= i_fin_valid;
            end
            if (w_s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready) begin
            r_s2 <= w_s2;
        end
        if (w_s3_ready) begin
            r_s3 <= w_s3;
        end
        if (w_out_ready) begin
            r_out <= w_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_string_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_STR)) |->
            ((r_out.int_value == '0) && (r_out.mantissa == '0) && !r_out.overflow))
        else $error("string result carries nonzero fields");

    a_float_no_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_FLT)) |-> (r_out.int_value == '0))
        else $error("float result carries an integer value");

    a_sat_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3.int_sat) |-> r_s3.fin.ovf)
        else $error("saturated integer value without overflow flag");

endmodule

@@ hw/rtl/decimal_number_field_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_field_classifier_top
// Takes a text field one character per transaction and returns one result
// per field: kind, saturated integer value and mantissa / decimal exponent.
// ----------------------------------------------------------------------------
// One character is taken every cycle unless o_stall is high, with no gaps
// between fields. Each field (or empty request) yields exactly one result:
// the recognizer registers the finished record at the edge that takes its
// final character, then the range check, the partial-product multiply and the
// final sum of the integer value path are each registered in turn. Four results
// can be in flight, so input keeps flowing while a result waits at the output;
// input stalls only once all of them are held.
module decimal_number_field_classifier_top
    import dnfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_in,
    output logic o_stall,
    output logic o_valid,
    output t_out o_out,
    input  logic i_stall
);

    logic w_fin_valid;
    logic w_fin_ready;
    t_fin w_fin;

    dnfc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .o_stall     (o_stall),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin),
        .i_fin_ready (w_fin_ready)
    );

    dnfc_scaler u_scaler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (w_fin_valid),
        .i_fin       (w_fin),
        .o_fin_ready (w_fin_ready),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

endmodule
